[rtl/core/efr_pkg.sv]
package efr_pkg;

	localparam int PosW = 9;
	localparam int ByteW = 8;
	localparam int StatusW = 2;

	localparam logic [ByteW-1:0] START_CODE = 8'h7E;
	localparam logic [ByteW-1:0] ESC_CODE = 8'h7D;
	localparam logic [ByteW-1:0] ESC_XOR = 8'h20;
	localparam logic [ByteW-1:0] SUM_GOOD = 8'hFF;
	localparam logic [PosW-1:0] SUM_FROM = 9'd3;
	localparam logic [PosW-1:0] LEN_LOW_POS = 9'd2;
	localparam logic [PosW-1:0] POS_MAX = 9'd258;
	localparam logic [PosW-1:0] LIMIT_RESET = 9'd128;

	localparam logic [StatusW-1:0] ST_OK = 2'd0;
	localparam logic [StatusW-1:0] ST_CHECKSUM = 2'd1;
	localparam logic [StatusW-1:0] ST_OVERFLOW = 2'd2;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_END = 1'b1;

	// receiver state carried from word to word
	typedef struct packed {
		logic [PosW-1:0] byte_position;
		logic escape_pending;
		logic [ByteW-1:0] running_sum;
		logic [ByteW-1:0] length_low;
	} efr_state_t;

	// one result word
	typedef struct packed {
		logic kind;
		logic [PosW-1:0] position;
		logic [ByteW-1:0] data_byte;
		logic [StatusW-1:0] status;
		logic [PosW-1:0] frame_length;
	} efr_result_t;

endpackage

[rtl/core/efr_decode.sv]
module efr_decode (
	input  efr_pkg::efr_state_t cur,
	input  logic [efr_pkg::ByteW-1:0] raw_byte,
	input  logic [efr_pkg::PosW-1:0] frame_limit,
	output efr_pkg::efr_state_t nxt,
	output logic has_result,
	output efr_pkg::efr_result_t result
);
	import efr_pkg::*;

	always_comb begin
		logic [ByteW-1:0] b;
		logic [ByteW-1:0] sum_new;
		logic go;

		nxt = cur;
		has_result = 1'b0;
		result = '0;
		b = raw_byte;
		go = 1'b0;
		sum_new = cur.running_sum;

		if (cur.escape_pending) begin
			b = raw_byte ^ ESC_XOR;
			nxt.escape_pending = 1'b0;
			go = 1'b1;
		end else if (raw_byte == START_CODE) begin
			nxt.byte_position = 9'd1;
			nxt.running_sum = '0;
		end else if (cur.byte_position != '0 && raw_byte == ESC_CODE) begin
			nxt.escape_pending = 1'b1;
		end else begin
			go = 1'b1;
		end

		if (go && cur.byte_position != '0) begin
			if (cur.byte_position >= SUM_FROM) begin
				sum_new = cur.running_sum + b;
			end
			has_result = 1'b1;
			if (cur.byte_position > frame_limit) begin
				result.kind = KIND_END;
				result.position = cur.byte_position;
				result.status = ST_OVERFLOW;
				nxt.byte_position = '0;
				nxt.running_sum = '0;
			end else if (cur.byte_position > LEN_LOW_POS &&
				cur.byte_position == ({1'b0, cur.length_low} + SUM_FROM)) begin
				result.kind = KIND_END;
				result.position = cur.byte_position;
				result.status = (sum_new == SUM_GOOD) ? ST_OK : ST_CHECKSUM;
				result.frame_length = cur.byte_position;
				nxt.byte_position = '0;
				nxt.running_sum = '0;
			end else begin
				if (cur.byte_position == LEN_LOW_POS) begin
					nxt.length_low = b;
				end
				result.kind = KIND_DATA;
				result.position = cur.byte_position;
				result.data_byte = b;
				nxt.byte_position = cur.byte_position + 9'd1;
				nxt.running_sum = sum_new;
			end
		end
	end

endmodule

[rtl/core/escaped_frame_receiver_unit.sv]
// channel  | handshake            | payload
// ---------+----------------------+---------------------------------------------
// in       | in_valid / in_stall  | rx_byte
// out      | out_valid / out_stall| kind, position, data_byte, status, frame_length
// cfg      | cfg_valid / cfg_ready| frame_limit
//
// one word per cycle sustained unless out_stall backs up; a word waits in the
// input register and its result, if any, is registered in the output register
// the only loop is the frame state update in efr_decode, one step per word
// arst_n clears the frame state, both valid flags and sets frame_limit to 128
// out_stall holds the output register; the input register drains into it when
// it frees up or when the pending word makes no result, otherwise in_stall rises
module escaped_frame_receiver_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [efr_pkg::ByteW-1:0] rx_byte,
	output logic out_valid,
	input  logic out_stall,
	output logic kind,
	output logic [efr_pkg::PosW-1:0] position,
	output logic [efr_pkg::ByteW-1:0] data_byte,
	output logic [efr_pkg::StatusW-1:0] status,
	output logic [efr_pkg::PosW-1:0] frame_length,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [efr_pkg::PosW-1:0] frame_limit
);
	import efr_pkg::*;

	// configuration register, always writable
	logic [PosW-1:0] limit_q;

	// input register
	logic valid_s1;
	logic [ByteW-1:0] byte_s1;

	// frame state
	efr_state_t state_q;
	efr_state_t state_nxt;

	// output register
	logic out_valid_q;
	efr_result_t res_q;

	logic has_result;
	efr_result_t result;
	logic out_free;
	logic advance_s1;
	logic in_accept;

	assign cfg_ready = 1'b1;

	efr_decode u_decode (
		.cur(state_q),
		.raw_byte(byte_s1),
		.frame_limit(limit_q),
		.nxt(state_nxt),
		.has_result(has_result),
		.result(result)
	);

	// output register can take a new word if empty or being drained
	assign out_free = !out_valid_q || !out_stall;
	// a word that makes no result never waits on the output side
	assign advance_s1 = valid_s1 && (!has_result || out_free);
	assign in_stall = valid_s1 && !advance_s1;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= frame_limit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1 <= rx_byte;
		end
	end

	// state moves only when the pending word is decoded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && has_result) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && has_result) begin
			res_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign kind = res_q.kind;
	assign position = res_q.position;
	assign data_byte = res_q.data_byte;
	assign status = res_q.status;
	assign frame_length = res_q.frame_length;

	// a frame end always leaves the receiver outside any frame
	a_end_closes_frame: assert property (@(posedge clk) disable iff (!arst_n)
		advance_s1 && has_result && result.kind == KIND_END |=> state_q.byte_position == '0)
		else $error("frame end did not close the frame");

	// position can never run past the longest possible frame
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.byte_position <= POS_MAX)
		else $error("byte position out of range");

	// a data word carries a real position and no status fields
	a_data_word_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.kind == KIND_DATA |->
		res_q.position != '0 && res_q.status == ST_OK && res_q.frame_length == '0)
		else $error("malformed data word");

	// a held result word is not overwritten
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(res_q))
		else $error("stalled result changed");

endmodule

[bench/escaped_frame_receiver_unit_tb.sv]
module escaped_frame_receiver_unit_tb;
	import efr_pkg::*;

	// clock, reset and every block input start at known values
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [ByteW-1:0] rx_byte = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic kind;
	logic [PosW-1:0] position;
	logic [ByteW-1:0] data_byte;
	logic [StatusW-1:0] status;
	logic [PosW-1:0] frame_length;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [PosW-1:0] frame_limit = LIMIT_RESET;

	// shadow of the receiver: frame position, escape flag, checksum, length low
	logic [PosW-1:0] rx_pos = '0;
	logic rx_esc = 1'b0;
	logic [ByteW-1:0] rx_sum = '0;
	logic [ByteW-1:0] rx_len_low = '0;
	logic [PosW-1:0] limit_copy = LIMIT_RESET;

	// decoded words still owed by the block, oldest first
	efr_result_t awaited_words[$];

	// idling knobs, percent
	int idle_pct = 0;
	int stall_pct = 0;

	// bookkeeping
	int n_errors = 0;
	int n_bytes = 0;
	int n_data = 0;
	int n_ok = 0;
	int n_cksum = 0;
	int n_ovf = 0;

	escaped_frame_receiver_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.position(position),
		.data_byte(data_byte),
		.status(status),
		.frame_length(frame_length),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.frame_limit(frame_limit)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// hard stop in case the block hangs
	initial begin
		#4000000;
		$display("escaped_frame_receiver_unit_tb: errors");
		$finish;
	end

	// receiver back-pressure, independent of out_valid
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// one raw byte through the shadow receiver; returns 1 when it yields a word
	function automatic bit decode_byte(input logic [ByteW-1:0] raw, output efr_result_t word);
		logic [ByteW-1:0] b;
		logic [PosW-1:0] p;
		b = raw;
		word = '0;
		if (rx_esc) begin
			// byte after an escape is flipped and never opens a frame
			b = b ^ ESC_XOR;
			rx_esc = 1'b0;
		end else if (b == START_CODE) begin
			rx_pos = 9'd1;
			rx_sum = '0;
			return 1'b0;
		end else if (rx_pos != '0 && b == ESC_CODE) begin
			// escape is only special inside a frame
			rx_esc = 1'b1;
			return 1'b0;
		end
		p = rx_pos;
		if (p == '0)
			return 1'b0;
		if (p >= SUM_FROM)
			rx_sum = rx_sum + b;
		// overflow wins over the end check
		if (p > limit_copy) begin
			word.kind = KIND_END;
			word.position = p;
			word.status = ST_OVERFLOW;
			rx_pos = '0;
			rx_sum = '0;
			return 1'b1;
		end
		if (p > LEN_LOW_POS && p == {1'b0, rx_len_low} + SUM_FROM) begin
			word.kind = KIND_END;
			word.position = p;
			word.status = (rx_sum == SUM_GOOD) ? ST_OK : ST_CHECKSUM;
			word.frame_length = p;
			rx_pos = '0;
			rx_sum = '0;
			return 1'b1;
		end
		if (p == LEN_LOW_POS)
			rx_len_low = b;
		word.kind = KIND_DATA;
		word.position = p;
		word.data_byte = b;
		rx_pos = p + 9'd1;
		return 1'b1;
	endfunction

	// payload byte, leaning toward the start and escape codes now and then
	function automatic logic [ByteW-1:0] frame_content();
		case ($urandom_range(0, 15))
			0: frame_content = START_CODE;
			1: frame_content = ESC_CODE;
			default: frame_content = 8'($urandom);
		endcase
	endfunction

	// push one raw byte into the input channel, with an optional idle gap first
	task automatic send_byte(input logic [ByteW-1:0] b);
		efr_result_t word;
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		n_bytes++;
		if (decode_byte(b, word))
			awaited_words.push_back(word);
	endtask

	// byte-stuffed send: codes are always escaped, other bytes sometimes
	task automatic send_stuffed(input logic [ByteW-1:0] b);
		if (b == START_CODE || b == ESC_CODE || $urandom_range(0, 9) == 0) begin
			send_byte(ESC_CODE);
			send_byte(b ^ ESC_XOR);
		end else begin
			send_byte(b);
		end
	endtask

	// full frame: start, length high, length low, payload, checksum
	task automatic send_frame(input int len, input bit good);
		logic [ByteW-1:0] sum;
		logic [ByteW-1:0] b;
		sum = '0;
		send_byte(START_CODE);
		send_stuffed(frame_content());
		send_stuffed(len[7:0]);
		for (int i = 0; i < len; i++) begin
			b = frame_content();
			sum = sum + b;
			send_stuffed(b);
		end
		b = SUM_GOOD - sum;
		if (!good)
			b = b ^ 8'($urandom_range(1, 255));
		send_stuffed(b);
	endtask

	// sender holds off until every owed word is out and the pipe has emptied
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (awaited_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// frame limit write, only with the block idle
	task automatic set_limit(input logic [PosW-1:0] v);
		wait_drained();
		cfg_valid <= 1'b1;
		frame_limit <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		limit_copy = v;
	endtask

	// short hand-picked sequences at the reset limit
	task automatic test_directed();
		logic [ByteW-1:0] seq[$];
		seq = '{
			// outside a frame: dropped, escape code means nothing there
			8'h00, 8'hFF, ESC_CODE, 8'h5E,
			// empty frame, good checksum
			START_CODE, 8'h00, 8'h00, 8'hFF,
			// empty frame, bad checksum
			START_CODE, 8'h00, 8'h00, 8'h00,
			// escaped length low, then escaped start as data
			START_CODE, 8'hFF, ESC_CODE, 8'h21, ESC_CODE, START_CODE, 8'hA1,
			// start inside a frame restarts it
			START_CODE, 8'h12, START_CODE, 8'h00, 8'h00, 8'hFF
		};
		foreach (seq[i])
			send_byte(seq[i]);
	endtask

	// frame limit sweep: tight, degenerate, beyond any frame, one short of the top
	task automatic test_frame_limit();
		logic [ByteW-1:0] seq[$];
		set_limit(9'd4);
		seq = '{START_CODE, 8'h00, 8'h01, 8'hAA, 8'h54, START_CODE, 8'h00, 8'h02, 8'h11, 8'h22};
		foreach (seq[i])
			send_byte(seq[i]);
		// limit below the length bytes: overflow right after position 1
		set_limit(9'd1);
		seq = '{START_CODE, 8'h00, 8'h33};
		foreach (seq[i])
			send_byte(seq[i]);
		// zero limit: every frame dies at position 1
		set_limit(9'd0);
		seq = '{START_CODE, 8'h12};
		foreach (seq[i])
			send_byte(seq[i]);
		// all bits set: longest frame completes at the top position
		set_limit(9'h1FF);
		send_frame(255, 1'b1);
		// one short of the top: longest frame overflows on its last word
		set_limit(POS_MAX - 9'd1);
		send_frame(255, 1'b1);
	endtask

	// mostly well-formed frames with random content, some cut frames and noise
	task automatic test_random_traffic(input int idle, input int stall,
			input logic [PosW-1:0] lim, input int n);
		int stop;
		int roll;
		int k;
		int len;
		set_limit(lim);
		idle_pct = idle;
		stall_pct = stall;
		stop = n_bytes + n;
		while (n_bytes < stop) begin
			roll = $urandom_range(0, 99);
			if (roll < 80) begin
				k = $urandom_range(0, 99);
				if (k < 90)
					len = $urandom_range(0, 24);
				else if (k < 97)
					len = $urandom_range(25, 140);
				else
					len = $urandom_range(141, 255);
				send_frame(len, $urandom_range(0, 3) != 0);
			end else if (roll < 90) begin
				// cut frame, usually restarted by whatever comes next
				send_byte(START_CODE);
				repeat ($urandom_range(0, 6)) send_stuffed(frame_content());
			end else begin
				// raw line noise, escapes and starts included
				repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
			end
		end
	endtask

	// compare every accepted output word with the oldest owed word
	always @(posedge clk) begin : check_words
		efr_result_t got;
		efr_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got.kind = kind;
			got.position = position;
			got.data_byte = data_byte;
			got.status = status;
			got.frame_length = frame_length;
			if (awaited_words.size() == 0) begin
				$display("%0t: word with none owed: kind=%0d pos=%0d data=%02h st=%0d len=%0d",
					$time, got.kind, got.position, got.data_byte, got.status,
					got.frame_length);
				n_errors++;
			end else begin
				want = awaited_words.pop_front();
				if (got !== want) begin
					$display("%0t: expected kind=%0d pos=%0d data=%02h st=%0d len=%0d",
						$time, want.kind, want.position, want.data_byte, want.status,
						want.frame_length);
					$display("%0t:   actual kind=%0d pos=%0d data=%02h st=%0d len=%0d",
						$time, got.kind, got.position, got.data_byte, got.status,
						got.frame_length);
					n_errors++;
				end
			end
			// tally on what came out
			if (got.kind == KIND_DATA)
				n_data++;
			else if (got.status == ST_OK)
				n_ok++;
			else if (got.status == ST_CHECKSUM)
				n_cksum++;
			else
				n_ovf++;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_frame_limit();
		// back to the reset limit, no idling on either side
		test_random_traffic(0, 0, LIMIT_RESET, 170);
		// sender gaps only, random limit in range
		test_random_traffic(56, 0, 9'($urandom_range(4, 258)), 170);
		// receiver stalls only, no overflow possible
		test_random_traffic(0, 56, POS_MAX, 170);
		// both sides idling, tight limit so overflow is common
		test_random_traffic(38, 38, 9'($urandom_range(4, 40)), 170);
		wait_drained();
		$display("run covered %0d raw bytes and %0d data words", n_bytes, n_data);
		$display("frame ends seen: %0d ok, %0d bad checksum, %0d overflow",
			n_ok, n_cksum, n_ovf);
		if (n_errors == 0) begin
			$display("escaped_frame_receiver_unit_tb: clean");
		end else begin
			$display("escaped_frame_receiver_unit_tb: errors");
		end
		$finish;
	end

endmodule

[files.f]
rtl/core/efr_pkg.sv
rtl/core/efr_decode.sv
rtl/core/escaped_frame_receiver_unit.sv
bench/escaped_frame_receiver_unit_tb.sv
